// File: hdl/tecp_pkg.sv
// Shared types and constants for the text escape and colour parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tecp_pkg;

    // Printed characters allowed per string before the rest is dropped
    localparam int OUT_DEPTH   = 256;
    localparam int CNT_W       = $clog2(OUT_DEPTH + 1);

    // Decoupling queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Colour code digits kept for a flush (the eighth completes the code)
    localparam int DIGITS      = 7;

    localparam logic [7:0] CH_NUL     = 8'd0;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_RETURN  = 8'd13;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEFAULT_COLOR = 2'd0;
    localparam logic [1:0] CFG_ESCAPE_CODE   = 2'd1;
    localparam logic [1:0] CFG_MARKER_CODE   = 2'd2;

    localparam logic [31:0] RST_DEFAULT_COLOR = 32'hFFFF_FFFF;
    localparam logic [7:0]  RST_ESCAPE_CODE   = 8'd92;
    localparam logic [7:0]  RST_MARKER_CODE   = 8'd64;

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } in_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_escaped;
        logic [4:0] out_red;
        logic [4:0] out_green;
        logic [4:0] out_blue;
        logic [7:0] out_alpha;
        logic       out_run_end;
    } out_t;

    typedef struct packed {
        logic [31:0] default_color;
        logic [7:0]  escape_code;
        logic [7:0]  marker_code;
    } cfg_t;

    // One request's worth of printing: a head run (escape char, or the
    // marker plus its digits) then an optional tail char, cut to keep.
    typedef struct packed {
        logic [3:0]                  keep;
        logic [3:0]                  head_n;
        logic [7:0]                  head0;
        logic [DIGITS-1:0][7:0]      digits;
        logic [7:0]                  tail_char;
        logic                        tail_esc;
        logic [31:0]                 color;
    } cmd_t;

endpackage

// File: hdl/tecp_front.sv
// Front end: accepts characters, tracks escape and colour code state,
// and turns each request into one print command. Depends on tecp_pkg.
`timescale 1ns / 1ps

module tecp_front (
    input  logic           clk,
    input  logic           rst_n,
    input  tecp_pkg::cfg_t cfg,
    input  logic           accept,
    input  tecp_pkg::in_t  in_item,
    output logic           cmd_push,
    output tecp_pkg::cmd_t cmd
);
    import tecp_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(OUT_DEPTH);

    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'd48 && c <= 8'd57)
            r = {1'b1, c[3:0]};
        else if ((c >= 8'd65 && c <= 8'd70) || (c >= 8'd97 && c <= 8'd102))
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        return r;
    endfunction

    logic                   start_reg, start_next;
    logic [31:0]            color_reg, color_next;
    logic                   pend_reg, pend_next;
    logic                   coll_reg, coll_next;
    logic [2:0]             seen_reg, seen_next;
    logic [27:0]            hex_reg, hex_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   done_reg, done_next;
    logic [DIGITS-1:0][7:0] digit_reg, digit_next;

    logic [31:0]      st_color;
    logic             st_pend, st_coll, st_done;
    logic [2:0]       st_seen;
    logic [27:0]      st_hex;
    logic [CNT_W-1:0] st_count;

    logic [7:0]       c;
    logic             last;
    logic [4:0]       hx;
    logic             do_plain, is_special, tail_v, logic_done;
    logic [3:0]       head_n, total;
    logic [7:0]       head0, tail_char;
    logic             tail_esc;
    logic [CNT_W+3:0] total_ext, avail_ext, kept_ext;

    always_comb
    begin
        // string start reloads the colour and clears parsing state
        st_color = start_reg ? cfg.default_color : color_reg;
        st_pend  = start_reg ? 1'b0 : pend_reg;
        st_coll  = start_reg ? 1'b0 : coll_reg;
        st_seen  = start_reg ? 3'd0 : seen_reg;
        st_hex   = start_reg ? 28'd0 : hex_reg;
        st_count = start_reg ? '0 : count_reg;
        st_done  = start_reg ? 1'b0 : done_reg;

        c    = in_item.in_char;
        last = in_item.in_last;
        hx   = hex_decode(c);
        is_special = (c == cfg.escape_code) || (c == CH_TAB) || (c == CH_NEWLINE) ||
                     (c == CH_RETURN) || (c == cfg.marker_code);

        color_next = st_color;
        pend_next  = st_pend;
        coll_next  = st_coll;
        seen_next  = st_seen;
        hex_next   = st_hex;
        digit_next = digit_reg;
        logic_done = st_done;
        do_plain   = 1'b0;
        head_n     = 4'd0;
        head0      = cfg.marker_code;
        tail_v     = 1'b0;
        tail_char  = c;
        tail_esc   = 1'b0;

        if (!st_done)
        begin
            if (st_pend)
            begin
                pend_next = 1'b0;
                if (c == CH_NUL)
                begin
                    head_n     = 4'd1;
                    head0      = cfg.escape_code;
                    logic_done = 1'b1;
                end
                else if (is_special)
                begin
                    tail_v   = 1'b1;
                    tail_esc = 1'b1;
                end
                else
                begin
                    head_n   = 4'd1;
                    head0    = cfg.escape_code;
                    do_plain = 1'b1;
                end
            end
            else if (st_coll)
            begin
                if (c == CH_NUL)
                begin
                    head_n     = 4'd1 + 4'(st_seen);
                    coll_next  = 1'b0;
                    seen_next  = 3'd0;
                    hex_next   = 28'd0;
                    logic_done = 1'b1;
                end
                else if (hx[4])
                begin
                    if (st_seen == 3'd7)
                    begin
                        color_next = {st_hex, hx[3:0]};
                        coll_next  = 1'b0;
                        seen_next  = 3'd0;
                        hex_next   = 28'd0;
                    end
                    else if (last)
                    begin
                        head_n    = 4'd1 + 4'(st_seen);
                        tail_v    = 1'b1;
                        coll_next = 1'b0;
                        seen_next = 3'd0;
                        hex_next  = 28'd0;
                    end
                    else
                    begin
                        digit_next[st_seen] = c;
                        hex_next  = {st_hex[23:0], hx[3:0]};
                        seen_next = st_seen + 3'd1;
                    end
                end
                else
                begin
                    head_n    = 4'd1 + 4'(st_seen);
                    coll_next = 1'b0;
                    seen_next = 3'd0;
                    hex_next  = 28'd0;
                    do_plain  = 1'b1;
                end
            end
            else
            begin
                do_plain = 1'b1;
            end

            if (do_plain)
            begin
                if (c == CH_NUL)
                    logic_done = 1'b1;
                else if (c == cfg.escape_code)
                begin
                    if (last)
                        tail_v = 1'b1;
                    else
                        pend_next = 1'b1;
                end
                else if (c == cfg.marker_code)
                begin
                    if (last)
                        tail_v = 1'b1;
                    else
                    begin
                        coll_next = 1'b1;
                        seen_next = 3'd0;
                        hex_next  = 28'd0;
                    end
                end
                else
                    tail_v = 1'b1;
            end
        end

        // clip to what is left of the string's print budget
        total     = head_n + 4'(tail_v);
        total_ext = {{CNT_W{1'b0}}, total};
        avail_ext = {4'd0, DEPTH_CNT - st_count};
        kept_ext  = (total_ext > avail_ext) ? avail_ext : total_ext;
        count_next = st_count + kept_ext[CNT_W-1:0];
        done_next  = logic_done || (count_next == DEPTH_CNT);
        start_next = last;

        cmd.keep      = kept_ext[3:0];
        cmd.head_n    = head_n;
        cmd.head0     = head0;
        cmd.digits    = digit_reg;
        cmd.tail_char = tail_char;
        cmd.tail_esc  = tail_esc;
        cmd.color     = st_color;
        cmd_push      = accept && (kept_ext[3:0] != 4'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= 1'b1;
            color_reg <= RST_DEFAULT_COLOR;
            pend_reg  <= 1'b0;
            coll_reg  <= 1'b0;
            seen_reg  <= 3'd0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else if (accept)
        begin
            start_reg <= start_next;
            color_reg <= color_next;
            pend_reg  <= pend_next;
            coll_reg  <= coll_next;
            seen_reg  <= seen_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hex_reg   <= hex_next;
            digit_reg <= digit_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("print count beyond buffer depth");

    a_full_means_done: assert property (@(posedge clk) disable iff (!rst_n)
        (!start_reg && count_reg == DEPTH_CNT) |-> done_reg)
        else $error("buffer full but string not marked done");

endmodule

// File: hdl/tecp_cmd_fifo.sv
// Short register queue of print commands between front and back.
// Depends on tecp_pkg for cmd_t and the queue depth.
`timescale 1ns / 1ps

module tecp_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tecp_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output tecp_pkg::cmd_t head,
    output logic           empty
);
    import tecp_pkg::*;

    localparam logic [QCNT_W-1:0] DEPTH_Q = QCNT_W'(QUEUE_DEPTH);
    localparam logic [QPTR_W-1:0] LAST_P  = QPTR_W'(QUEUE_DEPTH - 1);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;

    assign full  = (fill_reg == DEPTH_Q);
    assign empty = (fill_reg == '0);
    assign head  = entry_reg[rd_reg];

    always_comb
    begin
        wr_next   = wr_reg;
        rd_next   = rd_reg;
        fill_next = fill_reg;
        if (push)
            wr_next = (wr_reg == LAST_P) ? '0 : wr_reg + QPTR_W'(1);
        if (pop)
            rd_next = (rd_reg == LAST_P) ? '0 : rd_reg + QPTR_W'(1);
        if (push && !pop)
            fill_next = fill_reg + QCNT_W'(1);
        else if (pop && !push)
            fill_next = fill_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("command pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("command popped from empty queue");

endmodule

// File: hdl/tecp_back.sv
// Back end: expands each queued print command into result requests in the
// output register, one per cycle unless the receiver stalls. Depends on tecp_pkg.
`timescale 1ns / 1ps

module tecp_back (
    input  logic           clk,
    input  logic           rst_n,
    input  tecp_pkg::cmd_t head,
    input  logic           head_empty,
    output logic           head_pop,
    output logic           empty,
    input  logic           pop,
    output tecp_pkg::out_t out_item
);
    import tecp_pkg::*;

    logic       out_valid_reg, out_valid_next;
    out_t       out_reg, out_next;
    logic [3:0] idx_reg, idx_next;
    logic       advance, in_head;
    logic [2:0] dsel;

    always_comb
    begin
        advance  = !head_empty && (!out_valid_reg || pop);
        in_head  = (idx_reg < head.head_n);
        dsel     = idx_reg[2:0] - 3'd1;

        out_next = out_reg;
        if (in_head)
        begin
            out_next.out_char    = (idx_reg == 4'd0) ? head.head0 : head.digits[dsel];
            out_next.out_escaped = 1'b0;
        end
        else
        begin
            out_next.out_char    = head.tail_char;
            out_next.out_escaped = head.tail_esc;
        end
        out_next.out_red     = head.color[31:27];
        out_next.out_green   = head.color[23:19];
        out_next.out_blue    = head.color[15:11];
        out_next.out_alpha   = head.color[7:0];
        out_next.out_run_end = (idx_reg == head.keep - 4'd1);

        head_pop = advance && out_next.out_run_end;
        idx_next = idx_reg;
        if (advance)
            idx_next = head_pop ? 4'd0 : idx_reg + 4'd1;

        if (advance)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 4'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= out_next;
    end

    assign empty    = !out_valid_reg;
    assign out_item = out_reg;

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !head_empty |-> (idx_reg < head.keep))
        else $error("expansion index past command length");

endmodule

// File: hdl/text_escape_color_parser.sv
// Top level of the text escape and colour parser: configuration registers,
// front end, command queue and back end. Depends on tecp_pkg and submodules.
`timescale 1ns / 1ps

// Usage
//   Input channel: drive in_item and raise push; the character is taken at a
//   rising edge with push high and full low. One character per cycle.
//   Result channel: while empty is low, out_item holds the oldest printable
//   character with its escaped flag and colour; pop takes it. out_run_end
//   marks the last result caused by one input character.
//   Configuration: cfg_we writes cfg_data into register cfg_index (0 default
//   colour, 1 escape code, 2 colour marker) at the clock edge; write only
//   while the block is idle.
// Path: a character's command is written into the queue as the character
//   is taken, and each result it prints then passes through the back end's
//   output register, in order.
// Throughput: one input character per cycle while every character prints at
//   most one result. A broken colour code flushes up to nine results, one per
//   cycle while the receiver keeps popping; the four-entry command queue
//   absorbs that, and full rises only once the queue is full.
// Reset: all parsing state clears, configuration returns to white, escape
//   92 and marker 64, and the next character starts a new string.
// Receiver stall: the output register holds its result, the queue fills, and
//   full is raised; no result is lost or repeated.

module text_escape_color_parser (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  tecp_pkg::in_t  in_item,
    output logic           empty,
    input  logic           pop,
    output tecp_pkg::out_t out_item,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [31:0]    cfg_data
);
    import tecp_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic accept;
    logic cmd_push, q_full, q_empty, q_pop;
    cmd_t cmd, q_head;

    // Configuration registers: plain write port, no read-back
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEFAULT_COLOR: cfg_next.default_color = cfg_data;
                CFG_ESCAPE_CODE:   cfg_next.escape_code   = cfg_data[7:0];
                CFG_MARKER_CODE:   cfg_next.marker_code   = cfg_data[7:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.default_color <= RST_DEFAULT_COLOR;
            cfg_reg.escape_code   <= RST_ESCAPE_CODE;
            cfg_reg.marker_code   <= RST_MARKER_CODE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Take a character whenever the queue has room for its command
    assign full   = q_full;
    assign accept = push && !q_full;

    tecp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .accept   (accept),
        .in_item  (in_item),
        .cmd_push (cmd_push),
        .cmd      (cmd)
    );

    tecp_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    tecp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .head_empty (q_empty),
        .head_pop   (q_pop),
        .empty      (empty),
        .pop        (pop),
        .out_item   (out_item)
    );

endmodule

// File: dv/tb_text_escape_color_parser.sv
// Self-checking testbench for text_escape_color_parser: directed strings, then
// random strings under several register settings. Needs tecp_pkg and the RTL.
`timescale 1ns / 1ps

module tb_text_escape_color_parser;

    import tecp_pkg::*;

    // Longest run of cycles with no request moving on either side before we
    // give up.
    localparam int WATCHDOG_LIMIT = 2000;
    // Quiet cycles after the last expected print, before a register write
    // or the final check, so that a request still in flight shows up.
    localparam int SETTLE_CYCLES  = 24;

    // ------------------------------------------------------------------
    // Scoreboard: tracks the parser state on every accepted request and
    // queues the prints that request causes; results are checked in order.
    // ------------------------------------------------------------------
    class print_scoreboard;
        bit [31:0]   dflt_colour;
        bit [7:0]    esc_ch;
        bit [7:0]    mark_ch;

        bit [31:0]   cur_colour;
        bit          esc_pending;
        bit          collecting;
        int unsigned digits_seen;
        bit [31:0]   hex_acc;
        int unsigned printed;
        bit          str_done;
        bit          str_start;
        bit [7:0]    digit_buf [8];

        out_t        step_prints [$];
        out_t        expected_prints [$];

        int unsigned errors;
        int unsigned n_reqs;
        int unsigned n_prints;
        int unsigned n_colour_sets;
        int unsigned n_dropped;

        function new();
            dflt_colour = RST_DEFAULT_COLOR;
            esc_ch      = RST_ESCAPE_CODE;
            mark_ch     = RST_MARKER_CODE;
            cur_colour  = RST_DEFAULT_COLOR;
            esc_pending = 1'b0;
            collecting  = 1'b0;
            digits_seen = 0;
            hex_acc     = '0;
            printed     = 0;
            str_done    = 1'b0;
            str_start   = 1'b1;
            foreach (digit_buf[i])
                digit_buf[i] = '0;
            errors        = 0;
            n_reqs        = 0;
            n_prints      = 0;
            n_colour_sets = 0;
            n_dropped     = 0;
        endfunction

        function void write_cfg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                CFG_DEFAULT_COLOR: dflt_colour = data;
                CFG_ESCAPE_CODE:   esc_ch      = data[7:0];
                CFG_MARKER_CODE:   mark_ch     = data[7:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_prints.size();
        endfunction

        function int hex_nibble(bit [7:0] c);
            if (c >= "0" && c <= "9")
                return c - "0";
            if (c >= "A" && c <= "F")
                return c - "A" + 10;
            if (c >= "a" && c <= "f")
                return c - "a" + 10;
            return -1;
        endfunction

        function bit is_special(bit [7:0] c);
            return c == esc_ch || c == CH_TAB || c == CH_NEWLINE ||
                   c == CH_RETURN || c == mark_ch;
        endfunction

        // One printed character; past the buffer depth it is dropped and the
        // rest of the string is discarded.
        function void put_char(bit [7:0] c, bit esc);
            out_t p;
            if (printed >= OUT_DEPTH)
            begin
                str_done = 1'b1;
                n_dropped++;
                return;
            end
            p.out_char    = c;
            p.out_escaped = esc;
            p.out_red     = cur_colour[31:27];
            p.out_green   = cur_colour[23:19];
            p.out_blue    = cur_colour[15:11];
            p.out_alpha   = cur_colour[7:0];
            p.out_run_end = 1'b0;
            step_prints.push_back(p);
            printed++;
            if (printed >= OUT_DEPTH)
                str_done = 1'b1;
        endfunction

        // Broken colour code: marker and the digits so far print plain
        function void flush_code();
            collecting = 1'b0;
            put_char(mark_ch, 1'b0);
            for (int i = 0; i < digits_seen && i < 8; i++)
                put_char(digit_buf[i], 1'b0);
            digits_seen = 0;
            hex_acc     = '0;
        endfunction

        function void plain_char(bit [7:0] c, bit last);
            if (c == CH_NUL)
                str_done = 1'b1;
            else if (c == esc_ch)
            begin
                if (last)
                    put_char(c, 1'b0);
                else
                    esc_pending = 1'b1;
            end
            else if (c == mark_ch)
            begin
                if (last)
                    put_char(c, 1'b0);
                else
                begin
                    collecting  = 1'b1;
                    digits_seen = 0;
                    hex_acc     = '0;
                end
            end
            else
                put_char(c, 1'b0);
        endfunction

        function void note_request(in_t req);
            bit [7:0] c;
            bit       last;
            int       h;
            c    = req.in_char;
            last = req.in_last;
            step_prints.delete();
            n_reqs++;

            if (str_start)
            begin
                str_start   = 1'b0;
                cur_colour  = dflt_colour;
                esc_pending = 1'b0;
                collecting  = 1'b0;
                digits_seen = 0;
                hex_acc     = '0;
                printed     = 0;
                str_done    = 1'b0;
            end

            if (!str_done)
            begin
                if (esc_pending)
                begin
                    esc_pending = 1'b0;
                    if (c == CH_NUL)
                    begin
                        put_char(esc_ch, 1'b0);
                        str_done = 1'b1;
                    end
                    else if (is_special(c))
                        put_char(c, 1'b1);
                    else
                    begin
                        put_char(esc_ch, 1'b0);
                        if (!str_done)
                            plain_char(c, last);
                    end
                end
                else if (collecting)
                begin
                    h = hex_nibble(c);
                    if (c == CH_NUL)
                    begin
                        flush_code();
                        str_done = 1'b1;
                    end
                    else if (h >= 0)
                    begin
                        if (digits_seen >= 7)
                        begin
                            cur_colour  = {hex_acc[27:0], h[3:0]};
                            collecting  = 1'b0;
                            digits_seen = 0;
                            hex_acc     = '0;
                            n_colour_sets++;
                        end
                        else if (last)
                        begin
                            flush_code();
                            put_char(c, 1'b0);
                        end
                        else
                        begin
                            digit_buf[digits_seen % 8] = c;
                            hex_acc = {hex_acc[27:0], h[3:0]};
                            digits_seen++;
                        end
                    end
                    else
                    begin
                        flush_code();
                        if (!str_done)
                            plain_char(c, last);
                    end
                end
                else
                    plain_char(c, last);
            end

            if (last)
                str_start = 1'b1;
            if (step_prints.size() > 0)
                step_prints[step_prints.size() - 1].out_run_end = 1'b1;
            foreach (step_prints[i])
                expected_prints.push_back(step_prints[i]);
            n_prints += step_prints.size();
        endfunction

        function void flag(string msg);
            if (errors < 10)
                $display("%0t ns: %s", $time, msg);
            errors++;
        endfunction

        function string show(out_t p);
            return $sformatf("char %02h esc %0d rgb %02h/%02h/%02h alpha %02h end %0d",
                             p.out_char, p.out_escaped, p.out_red, p.out_green,
                             p.out_blue, p.out_alpha, p.out_run_end);
        endfunction

        function void check_result(out_t got);
            out_t exp;
            if (expected_prints.size() == 0)
            begin
                flag($sformatf("unexpected print: %s", show(got)));
                return;
            end
            exp = expected_prints.pop_front();
            if (got.out_char    !== exp.out_char    ||
                got.out_escaped !== exp.out_escaped ||
                got.out_red     !== exp.out_red     ||
                got.out_green   !== exp.out_green   ||
                got.out_blue    !== exp.out_blue    ||
                got.out_alpha   !== exp.out_alpha   ||
                got.out_run_end !== exp.out_run_end)
                flag($sformatf("print mismatch: expected %s, got %s", show(exp), show(got)));
        endfunction

        function void finish_check();
            if (expected_prints.size() != 0)
                flag($sformatf("%0d expected prints never arrived", expected_prints.size()));
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        push      = 1'b0;
    logic        full;
    in_t         in_item   = '0;
    logic        empty;
    logic        pop       = 1'b0;
    out_t        out_item;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = CFG_DEFAULT_COLOR;
    logic [31:0] cfg_data  = '0;

    print_scoreboard sb;

    // Characters of the string being built, and the codes now in force
    logic [7:0]  pending_chars [$];
    logic [7:0]  cur_esc  = RST_ESCAPE_CODE;
    logic [7:0]  cur_mark = RST_MARKER_CODE;

    int          send_burst = 0;
    int          recv_burst = 0;
    int          idle_cycles = 0;
    int          n_settings = 0;

    always #10 clk = ~clk;

    text_escape_color_parser u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Mostly back to back or short gaps, now and then a long one; a burst
    // mode gives stretches with no idling at all.
    function automatic int pick_gap(inout int burst_left);
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] rand_hex();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10)
            return 8'("0" + r);
        if (r < 16)
            return 8'("A" + r - 10);
        return 8'("a" + r - 16);
    endfunction

    function automatic logic [7:0] pick_special();
        case ($urandom_range(0, 4))
            0:       return CH_TAB;
            1:       return CH_NEWLINE;
            2:       return CH_RETURN;
            3:       return cur_esc;
            default: return cur_mark;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request side: inputs change on the falling edge, the handshake is
    // judged on the rising edge. push stays high between back-to-back
    // requests so it is never lowered and raised in one step.
    // ------------------------------------------------------------------
    task automatic send_request(input in_t req);
        int gap;
        gap = pick_gap(send_burst);
        repeat (gap)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push    <= 1'b1;
        in_item <= req;
        do
            @(posedge clk);
        while (full);
        sb.note_request(req);
    endtask

    // Sends the built string; in_last rides on its final character
    task automatic send_string();
        in_t req;
        foreach (pending_chars[i])
        begin
            req.in_char = pending_chars[i];
            req.in_last = (i == pending_chars.size() - 1);
            send_request(req);
        end
        pending_chars.delete();
    endtask

    // Registers change only with the block idle and at a string boundary:
    // every expected print is out, then the settle wait.
    task automatic write_settings(input logic [31:0] colour, input logic [7:0] esc,
                                  input logic [7:0] mark);
        @(negedge clk);
        push <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DEFAULT_COLOR;
        cfg_data  <= colour;
        sb.write_cfg(CFG_DEFAULT_COLOR, colour);
        @(negedge clk);
        cfg_index <= CFG_ESCAPE_CODE;
        cfg_data  <= {24'd0, esc};
        sb.write_cfg(CFG_ESCAPE_CODE, {24'd0, esc});
        @(negedge clk);
        cfg_index <= CFG_MARKER_CODE;
        cfg_data  <= {24'd0, mark};
        sb.write_cfg(CFG_MARKER_CODE, {24'd0, mark});
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_esc  = esc;
        cur_mark = mark;
        n_settings++;
    endtask

    // One chunk of a random string. Arbitrary bytes are the largest share, and
    // escapes and full colour codes come often so the deeper states get
    // exercised; broken codes, specials and zeros make up the rest.
    task automatic add_token();
        int         r;
        int         k;
        logic [7:0] c;
        r = $urandom_range(0, 99);
        if (r < 40)
            pending_chars.push_back(8'($urandom_range(1, 255)));
        else if (r < 55)
        begin
            pending_chars.push_back(cur_esc);
            if ($urandom_range(0, 9) < 6)
                pending_chars.push_back(pick_special());
            else
                pending_chars.push_back(8'($urandom_range(0, 255)));
        end
        else if (r < 70)
        begin
            pending_chars.push_back(cur_mark);
            repeat (8)
                pending_chars.push_back(rand_hex());
        end
        else if (r < 80)
        begin
            // colour code cut short by zero or by a non-hex character
            pending_chars.push_back(cur_mark);
            k = $urandom_range(0, 7);
            repeat (k)
                pending_chars.push_back(rand_hex());
            if ($urandom_range(0, 3) == 0)
                pending_chars.push_back(CH_NUL);
            else
            begin
                do
                    c = 8'($urandom_range(1, 255));
                while (sb.hex_nibble(c) >= 0);
                pending_chars.push_back(c);
            end
        end
        else if (r < 90)
            pending_chars.push_back(pick_special());
        else if (r < 95)
            pending_chars.push_back(CH_NUL);
        else
            pending_chars.push_back(8'($urandom_range(0, 255)));
    endtask

    // Random strings, mostly short; some are cut at a random point so that
    // in_last lands inside an escape or a colour code.
    task automatic run_random(input int n_items);
        int sent;
        int n_tok;
        int cut;
        sent = 0;
        while (sent < n_items)
        begin
            n_tok = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8)
                                                 : $urandom_range(9, 25);
            repeat (n_tok)
                add_token();
            if ($urandom_range(0, 99) < 15)
            begin
                cut = $urandom_range(1, pending_chars.size());
                while (pending_chars.size() > cut)
                    void'(pending_chars.pop_back());
            end
            sent += pending_chars.size();
            send_string();
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: pop idles at random, each accepted print is checked
    // against the oldest expectation.
    // ------------------------------------------------------------------
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = pick_gap(recv_burst);
            repeat (gap)
            begin
                @(negedge clk);
                pop <= 1'b0;
            end
            @(negedge clk);
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
            sb.check_result(out_item);
        end
    end

    // Watchdog: cycles in which no request moves on either side
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [7:0] c;
        logic [7:0] same_code;
        sb = new();
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset values, written explicitly
        write_settings(RST_DEFAULT_COLOR, RST_ESCAPE_CODE, RST_MARKER_CODE);

        // Directed strings
        // escape then zero: escape prints plain, trailing char ignored
        pending_chars = '{cur_esc, CH_NUL, "x"};
        send_string();
        // escape alone as last char
        pending_chars = '{cur_esc};
        send_string();
        // marker alone as last char
        pending_chars = '{cur_mark};
        send_string();
        // escaped tab, marker and escape; escape before a plain char; top code
        pending_chars = '{cur_esc, CH_TAB, cur_esc, cur_mark, cur_esc, cur_esc,
                          cur_esc, "Q", 8'hFF};
        send_string();
        // colour code broken by a non-hex last char
        pending_chars = '{cur_mark, "F", "0", "a", 8'h01};
        send_string();
        // colour code cut by in_last on a hex digit: that digit prints plain
        pending_chars = '{cur_mark, "1", "2"};
        send_string();
        // colour code broken by zero
        pending_chars = '{cur_mark, "7", CH_NUL};
        send_string();

        // One string longer than the print buffer
        repeat (260)
        begin
            do
                c = 8'($urandom_range(1, 255));
            while (c == cur_esc || c == cur_mark);
            pending_chars.push_back(c);
        end
        send_string();
        run_random(20);

        // Extremes: black, escape zero, marker all-ones
        write_settings(32'h0000_0000, 8'h00, 8'hFF);
        run_random(20);

        write_settings($urandom, 8'hFF, 8'h00);
        run_random(20);

        // Escape and marker share one code: escape wins
        same_code = 8'($urandom_range(33, 126));
        write_settings($urandom, same_code, same_code);
        run_random(20);

        write_settings($urandom, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        run_random(20);

        // Drain and let anything late show up
        @(negedge clk);
        push <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
        sb.finish_check();

        $display("Run covered %0d requests under %0d register settings, %0d prints checked.",
                 sb.n_reqs, n_settings, sb.n_prints);
        $display("%0d colour codes applied, %0d prints dropped at the buffer limit.",
                 sb.n_colour_sets, sb.n_dropped);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
